### design/etpe_pkg.sv
// shared constants and codes for the eased tween position engine
`default_nettype none
package etpe_pkg;

  localparam int unsigned SINE_DEPTH_DEF = 256;
  localparam int unsigned ONE_Q16 = 65536;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  // divisors of the taylor terms of the sine series, (2k)(2k+1)
  localparam logic [63:0] TERM_DIV [1:8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  localparam int unsigned QUOT_W = 16;
  localparam int unsigned DIV_CNT_W = $clog2(QUOT_W + 1);

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  localparam logic [2:0] CFG_DURATION = 3'd0;
  localparam logic [2:0] CFG_LOOP     = 3'd1;
  localparam logic [2:0] CFG_EASING   = 3'd2;
  localparam logic [2:0] CFG_BACK_S   = 3'd3;
  localparam logic [2:0] CFG_START_X  = 3'd4;
  localparam logic [2:0] CFG_END_X    = 3'd5;
  localparam logic [2:0] CFG_START_Y  = 3'd6;
  localparam logic [2:0] CFG_END_Y    = 3'd7;

  localparam logic [3:0] MODE_LINEAR      = 4'd0;
  localparam logic [3:0] MODE_SINE_OUT    = 4'd1;
  localparam logic [3:0] MODE_SINE_IN     = 4'd2;
  localparam logic [3:0] MODE_SINE_INOUT  = 4'd3;
  localparam logic [3:0] MODE_QUAD_OUT    = 4'd4;
  localparam logic [3:0] MODE_QUAD_IN     = 4'd5;
  localparam logic [3:0] MODE_QUAD_INOUT  = 4'd6;
  localparam logic [3:0] MODE_BNC_OUT     = 4'd7;
  localparam logic [3:0] MODE_BNC_IN      = 4'd8;
  localparam logic [3:0] MODE_BNC_INOUT   = 4'd9;
  localparam logic [3:0] MODE_BACK_OUT    = 4'd10;
  localparam logic [3:0] MODE_BACK_IN     = 4'd11;
  localparam logic [3:0] MODE_BACK_INOUT  = 4'd12;

  localparam logic [13:0] BACK_S_RESET = 14'd6970;

endpackage
`default_nettype wire

### design/eased_tween_position_engine.sv
// top level: tick sequencer, shared multiplier, easing curves and interpolation
`default_nettype none
// Eased tween position engine. Start and stop items only set a pending flag; a tick
// acts on them. A tick of a running animation produces one result item with linear
// progress, eased progress and the interpolated x and y positions. Such a tick holds the
// input while it passes through the bit-serial divider when the end is not yet reached,
// then the easing, the interpolation and the hand-over to the output register, all
// multiplications going through one shared 22x32 multiplier in sequence. The hand-over
// waits while an earlier item is still stalled at the output. The input stalls while a
// tick is worked on; one finished result may wait in the output register while the next
// item is taken. Configuration writes are accepted in every cycle and are meant for idle
// times.
module eased_tween_position_engine #(
  parameter int unsigned SINE_TABLE_DEPTH = etpe_pkg::SINE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_opcode,
  input  wire logic [31:0]        in_now_ms,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [16:0]             out_raw_progress,
  output logic signed [17:0]      out_eased_progress,
  output logic signed [15:0]      out_pos_x,
  output logic signed [15:0]      out_pos_y,
  output logic                    out_finished,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  import etpe_pkg::*;

  localparam int unsigned IdxW = $clog2(SINE_TABLE_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_DIV, S_EASE,
    S_SIN_POS, S_SIN_RD, S_SIN_MUL, S_SIN_FIN,
    S_BNC_SQ, S_BNC_FIN,
    S_QUAD, S_QUAD_FIN,
    S_BK_SQ, S_BK_IN, S_BK_INNER, S_BK_MUL, S_BK_FIN,
    S_POST, S_LERP_X, S_POS_X, S_POS_Y, S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    POST_DIRECT, POST_MIRROR, POST_LO, POST_HI, POST_HALF
  } post_t;

  function automatic logic [16:0] sin_entry(input int unsigned i);
    logic [63:0] x, x2, term, pos, neg;
    int k;
    begin
      x    = (PI_HALF_Q30 * 64'(i) + 64'(SINE_TABLE_DEPTH / 2)) / 64'(SINE_TABLE_DEPTH);
      x2   = (x * x) >> 30;
      term = x;
      pos  = x;
      neg  = '0;
      for (k = 1; k <= 8; k++) begin
        term = ((term * x2) >> 30) / TERM_DIV[k];
        if (k % 2 == 1) neg = neg + term;
        else pos = pos + term;
      end
      if (i == SINE_TABLE_DEPTH) sin_entry = 17'(ONE_Q16);
      else sin_entry = 17'((pos - neg + 64'd8192) >> 14);
    end
  endfunction

  function automatic logic signed [53:0] rnd(input logic signed [53:0] v,
                                             input int unsigned k);
    rnd = (v + (54'sd1 <<< (k - 1))) >>> k;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
    if (v > 22'sd32767) sat16 = 16'sh7fff;
    else if (v < -22'sd32768) sat16 = 16'sh8000;
    else sat16 = 16'(v);
  endfunction

  logic [16:0] sin_tbl [0:SINE_TABLE_DEPTH];
  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_tbl
    assign sin_tbl[g] = sin_entry(g);
  end

  state_t              state_r, state_nxt;
  post_t               post_r, post_nxt;
  logic                start_pend_r, start_pend_nxt;
  logic                stop_pend_r, stop_pend_nxt;
  logic                running_r, running_nxt;
  logic [31:0]         start_time_r, start_time_nxt;
  logic [31:0]         dur_r, dur_nxt;
  logic                loop_r, loop_nxt;
  logic [3:0]          mode_r, mode_nxt;
  logic [13:0]         back_s_r, back_s_nxt;
  logic signed [15:0]  sx_r, sx_nxt, ex_r, ex_nxt, sy_r, sy_nxt, ey_r, ey_nxt;
  logic [16:0]         raw_r, raw_nxt;
  logic                fin_r, fin_nxt;
  logic signed [18:0]  q_r, q_nxt;
  logic                sh15_r, sh15_nxt;
  logic                bk_out_r, bk_out_nxt;
  logic signed [20:0]  f_r, f_nxt;
  logic [16:0]         a_r, a_nxt;
  logic signed [17:0]  diff_r, diff_nxt;
  logic [15:0]         frac_r, frac_nxt;
  logic signed [17:0]  add_r, add_nxt;
  logic signed [17:0]  sq_r, sq_nxt;
  logic signed [31:0]  inner_r, inner_nxt;
  logic signed [17:0]  e_r, e_nxt;
  logic signed [15:0]  px_r, px_nxt, py_r, py_nxt;
  logic signed [53:0]  prod_r, prod_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [16:0]         out_raw_r, out_raw_nxt;
  logic signed [17:0]  out_eased_r, out_eased_nxt;
  logic signed [15:0]  out_px_r, out_px_nxt, out_py_r, out_py_nxt;
  logic                out_fin_r, out_fin_nxt;

  logic signed [21:0]  mul_a;
  logic signed [31:0]  mul_b;
  logic [31:0]         tick_st, elapsed;
  logic                tick_run, at_end, stp;
  logic                div_start, div_done;
  logic [QUOT_W-1:0]   div_quot;
  logic                lo_half;
  logic signed [19:0]  t_s, one_s;
  logic [IdxW-1:0]     idx, idx_p1;
  logic [16:0]         qu;
  logic [21:0]         bx;
  logic signed [22:0]  bd;
  logic signed [22:0]  fe, pe;
  logic signed [16:0]  dx, dy;
  logic signed [31:0]  s_sh;

  assign tick_st  = start_pend_r ? in_now_ms : start_time_r;
  assign tick_run = start_pend_r | running_r;
  assign elapsed  = in_now_ms - tick_st;
  assign at_end   = (dur_r == '0) || (elapsed >= dur_r);

  assign lo_half = raw_r < 17'd32768;
  assign t_s     = signed'(20'(raw_r));
  assign one_s   = 20'sd65536;
  assign idx     = prod_r[16 +: IdxW];
  assign idx_p1  = idx + IdxW'(1);
  assign qu      = 17'(q_r);
  assign bx      = (22'(qu) << 4) + (22'(qu) << 2) + (22'(qu) << 1);
  assign fe      = 23'(f_r);
  assign dx      = 17'(ex_r) - 17'(sx_r);
  assign dy      = 17'(ey_r) - 17'(sy_r);
  assign s_sh    = signed'(32'({back_s_r, 16'h0000}));

  etpe_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (elapsed),
    .divisor  (dur_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    state_nxt      = state_r;
    post_nxt       = post_r;
    start_pend_nxt = start_pend_r;
    stop_pend_nxt  = stop_pend_r;
    running_nxt    = running_r;
    start_time_nxt = start_time_r;
    dur_nxt        = dur_r;
    loop_nxt       = loop_r;
    mode_nxt       = mode_r;
    back_s_nxt     = back_s_r;
    sx_nxt         = sx_r;
    ex_nxt         = ex_r;
    sy_nxt         = sy_r;
    ey_nxt         = ey_r;
    raw_nxt        = raw_r;
    fin_nxt        = fin_r;
    q_nxt          = q_r;
    sh15_nxt       = sh15_r;
    bk_out_nxt     = bk_out_r;
    f_nxt          = f_r;
    a_nxt          = a_r;
    diff_nxt       = diff_r;
    frac_nxt       = frac_r;
    add_nxt        = add_r;
    sq_nxt         = sq_r;
    inner_nxt      = inner_r;
    e_nxt          = e_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    out_valid_nxt  = out_valid_r;
    out_raw_nxt    = out_raw_r;
    out_eased_nxt  = out_eased_r;
    out_px_nxt     = out_px_r;
    out_py_nxt     = out_py_r;
    out_fin_nxt    = out_fin_r;
    mul_a          = '0;
    mul_b          = '0;
    div_start      = 1'b0;
    stp            = stop_pend_r;
    bd             = '0;
    pe             = '0;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_DURATION: dur_nxt    = cfg_data;
        CFG_LOOP:     loop_nxt   = cfg_data[0];
        CFG_EASING:   mode_nxt   = cfg_data[3:0];
        CFG_BACK_S:   back_s_nxt = cfg_data[13:0];
        CFG_START_X:  sx_nxt     = signed'(cfg_data[15:0]);
        CFG_END_X:    ex_nxt     = signed'(cfg_data[15:0]);
        CFG_START_Y:  sy_nxt     = signed'(cfg_data[15:0]);
        CFG_END_Y:    ey_nxt     = signed'(cfg_data[15:0]);
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_opcode)
            OP_START: begin
              start_pend_nxt = 1'b1;
              stop_pend_nxt  = 1'b0;
            end
            OP_STOP: begin
              start_pend_nxt = 1'b0;
              stop_pend_nxt  = 1'b1;
            end
            OP_TICK: begin
              start_time_nxt = tick_st;
              start_pend_nxt = 1'b0;
              running_nxt    = tick_run;
              if (tick_run) begin
                if (at_end) begin
                  start_pend_nxt = loop_r;
                  stp            = !loop_r;
                end
                // a pending stop still lets this tick's result out
                running_nxt   = !stp;
                stop_pend_nxt = 1'b0;
                fin_nxt       = at_end;
                raw_nxt       = 17'(ONE_Q16);
                div_start     = !at_end;
                state_nxt     = at_end ? S_EASE : S_DIV;
              end
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        if (div_done) begin
          raw_nxt   = {1'b0, div_quot};
          state_nxt = S_EASE;
        end
      end
      S_EASE: begin
        post_nxt   = POST_DIRECT;
        q_nxt      = 19'(t_s);
        sh15_nxt   = (mode_r == MODE_QUAD_INOUT);
        bk_out_nxt = 1'b0;
        case (mode_r)
          MODE_SINE_OUT, MODE_BNC_OUT: begin
            state_nxt = (mode_r == MODE_SINE_OUT) ? S_SIN_POS : S_BNC_SQ;
          end
          MODE_SINE_IN, MODE_BNC_IN: begin
            q_nxt     = 19'(one_s - t_s);
            post_nxt  = POST_MIRROR;
            state_nxt = (mode_r == MODE_SINE_IN) ? S_SIN_POS : S_BNC_SQ;
          end
          MODE_SINE_INOUT, MODE_BNC_INOUT: begin
            q_nxt     = lo_half ? 19'(one_s - (t_s <<< 1)) : 19'((t_s <<< 1) - one_s);
            post_nxt  = lo_half ? POST_LO : POST_HI;
            state_nxt = (mode_r == MODE_SINE_INOUT) ? S_SIN_POS : S_BNC_SQ;
          end
          MODE_QUAD_OUT, MODE_QUAD_IN: begin
            state_nxt = S_QUAD;
          end
          MODE_QUAD_INOUT: begin
            if (!lo_half) begin
              q_nxt    = 19'(one_s - t_s);
              post_nxt = POST_MIRROR;
            end
            state_nxt = S_QUAD;
          end
          MODE_BACK_OUT: begin
            q_nxt      = 19'(t_s - one_s);
            bk_out_nxt = 1'b1;
            state_nxt  = S_BK_SQ;
          end
          MODE_BACK_IN: begin
            state_nxt = S_BK_SQ;
          end
          MODE_BACK_INOUT: begin
            // lower half is back in on 2t, upper half back out on 2t-1
            q_nxt      = lo_half ? 19'(t_s <<< 1) : 19'((t_s <<< 1) - (one_s <<< 1));
            bk_out_nxt = !lo_half;
            post_nxt   = lo_half ? POST_HALF : POST_HI;
            state_nxt  = S_BK_SQ;
          end
          default: begin
            f_nxt     = 21'(t_s);
            state_nxt = S_POST;
          end
        endcase
      end
      S_SIN_POS: begin
        mul_a     = 22'(q_r);
        mul_b     = 32'(SINE_TABLE_DEPTH);
        state_nxt = S_SIN_RD;
      end
      S_SIN_RD: begin
        if (idx >= IdxW'(SINE_TABLE_DEPTH)) begin
          f_nxt     = signed'(21'(sin_tbl[SINE_TABLE_DEPTH]));
          state_nxt = S_POST;
        end else begin
          a_nxt     = sin_tbl[idx];
          diff_nxt  = signed'(18'(sin_tbl[idx_p1])) - signed'(18'(sin_tbl[idx]));
          frac_nxt  = prod_r[15:0];
          state_nxt = S_SIN_MUL;
        end
      end
      S_SIN_MUL: begin
        mul_a     = 22'(diff_r);
        mul_b     = signed'(32'(frac_r));
        state_nxt = S_SIN_FIN;
      end
      S_SIN_FIN: begin
        f_nxt     = signed'(21'(a_r)) + 21'(rnd(prod_r, 16));
        state_nxt = S_POST;
      end
      S_BNC_SQ: begin
        if (bx < 22'(8 * ONE_Q16)) begin
          bd      = signed'(23'(bx));
          add_nxt = 18'sd0;
        end else if (bx < 22'(16 * ONE_Q16)) begin
          bd      = signed'(23'(bx)) - 23'sd786432;
          add_nxt = 18'sd49152;
        end else if (bx < 22'(20 * ONE_Q16)) begin
          bd      = signed'(23'(bx)) - 23'sd1179648;
          add_nxt = 18'sd61440;
        end else begin
          bd      = signed'(23'(bx)) - 23'sd1376256;
          add_nxt = 18'sd64512;
        end
        mul_a     = 22'(bd);
        mul_b     = 32'(bd);
        state_nxt = S_BNC_FIN;
      end
      S_BNC_FIN: begin
        f_nxt     = 21'(rnd(prod_r, 22)) + 21'(add_r);
        state_nxt = S_POST;
      end
      S_QUAD: begin
        mul_a     = 22'(q_r);
        mul_b     = (mode_r == MODE_QUAD_OUT) ? 32'(20'sd131072 - 20'(q_r)) : 32'(q_r);
        state_nxt = S_QUAD_FIN;
      end
      S_QUAD_FIN: begin
        f_nxt     = sh15_r ? 21'(rnd(prod_r, 15)) : 21'(rnd(prod_r, 16));
        state_nxt = S_POST;
      end
      S_BK_SQ: begin
        mul_a     = 22'(q_r);
        mul_b     = 32'(q_r);
        state_nxt = S_BK_IN;
      end
      S_BK_IN: begin
        sq_nxt    = 18'(rnd(prod_r, 16));
        mul_a     = signed'(22'(15'(back_s_r) + 15'd4096));
        mul_b     = 32'(q_r);
        state_nxt = S_BK_INNER;
      end
      S_BK_INNER: begin
        inner_nxt = bk_out_r ? 32'(prod_r) + s_sh : 32'(prod_r) - s_sh;
        state_nxt = S_BK_MUL;
      end
      S_BK_MUL: begin
        mul_a     = 22'(sq_r);
        mul_b     = inner_r;
        state_nxt = S_BK_FIN;
      end
      S_BK_FIN: begin
        f_nxt     = 21'(rnd(prod_r, 28)) + (bk_out_r ? 21'sd65536 : 21'sd0);
        state_nxt = S_POST;
      end
      S_POST: begin
        case (post_r)
          POST_MIRROR: pe = 23'sd65536 - fe;
          POST_LO:     pe = (23'sd65536 - fe + 23'sd1) >>> 1;
          POST_HI:     pe = (23'sd65536 + fe + 23'sd1) >>> 1;
          POST_HALF:   pe = (fe + 23'sd1) >>> 1;
          default:     pe = fe;
        endcase
        if (pe > 23'sd131071) e_nxt = 18'sd131071;
        else if (pe < -23'sd65536) e_nxt = -18'sd65536;
        else e_nxt = 18'(pe);
        state_nxt = S_LERP_X;
      end
      S_LERP_X: begin
        mul_a     = 22'(dx);
        mul_b     = 32'(e_r);
        state_nxt = S_POS_X;
      end
      S_POS_X: begin
        px_nxt    = sat16(22'(sx_r) + 22'(rnd(prod_r, 16)));
        mul_a     = 22'(dy);
        mul_b     = 32'(e_r);
        state_nxt = S_POS_Y;
      end
      S_POS_Y: begin
        py_nxt    = sat16(22'(sy_r) + 22'(rnd(prod_r, 16)));
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // wait here only while an earlier item is still held at the output
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_raw_nxt   = raw_r;
          out_eased_nxt = e_r;
          out_px_nxt    = px_r;
          out_py_nxt    = py_r;
          out_fin_nxt   = fin_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    prod_nxt = 54'(mul_a) * 54'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      start_pend_r <= 1'b0;
      stop_pend_r  <= 1'b0;
      running_r    <= 1'b0;
      start_time_r <= '0;
      dur_r        <= '0;
      loop_r       <= 1'b0;
      mode_r       <= MODE_LINEAR;
      back_s_r     <= BACK_S_RESET;
      sx_r         <= '0;
      ex_r         <= '0;
      sy_r         <= '0;
      ey_r         <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      start_pend_r <= start_pend_nxt;
      stop_pend_r  <= stop_pend_nxt;
      running_r    <= running_nxt;
      start_time_r <= start_time_nxt;
      dur_r        <= dur_nxt;
      loop_r       <= loop_nxt;
      mode_r       <= mode_nxt;
      back_s_r     <= back_s_nxt;
      sx_r         <= sx_nxt;
      ex_r         <= ex_nxt;
      sy_r         <= sy_nxt;
      ey_r         <= ey_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    post_r      <= post_nxt;
    raw_r       <= raw_nxt;
    fin_r       <= fin_nxt;
    q_r         <= q_nxt;
    sh15_r      <= sh15_nxt;
    bk_out_r    <= bk_out_nxt;
    f_r         <= f_nxt;
    a_r         <= a_nxt;
    diff_r      <= diff_nxt;
    frac_r      <= frac_nxt;
    add_r       <= add_nxt;
    sq_r        <= sq_nxt;
    inner_r     <= inner_nxt;
    e_r         <= e_nxt;
    px_r        <= px_nxt;
    py_r        <= py_nxt;
    prod_r      <= prod_nxt;
    out_raw_r   <= out_raw_nxt;
    out_eased_r <= out_eased_nxt;
    out_px_r    <= out_px_nxt;
    out_py_r    <= out_py_nxt;
    out_fin_r   <= out_fin_nxt;
  end

  assign in_stall           = (state_r != S_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_raw_progress   = out_raw_r;
  assign out_eased_progress = out_eased_r;
  assign out_pos_x          = out_px_r;
  assign out_pos_y          = out_py_r;
  assign out_finished       = out_fin_r;

endmodule
`default_nettype wire

### design/etpe_divider.sv
// restoring divider, one quotient bit per cycle, for elapsed*65536/duration
`default_nettype none
module etpe_divider (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [31:0]                  dividend,
  input  wire logic [31:0]                  divisor,
  output logic                              done,
  output logic [etpe_pkg::QUOT_W-1:0]       quotient
);
  import etpe_pkg::*;

  logic [31:0]           rem_r, rem_nxt;
  logic [QUOT_W-1:0]     quot_r, quot_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                  done_r, done_nxt;
  logic [32:0]           sh;
  logic                  ge;

  // dividend is below divisor, so the shifted remainder stays under twice it
  assign sh = {rem_r, 1'b0};
  assign ge = sh >= {1'b0, divisor};

  always_comb begin
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = dividend;
      quot_nxt = '0;
      cnt_nxt  = DIV_CNT_W'(QUOT_W);
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? 32'(sh - {1'b0, divisor}) : sh[31:0];
      quot_nxt = {quot_r[QUOT_W-2:0], ge};
      cnt_nxt  = cnt_r - DIV_CNT_W'(1);
      done_nxt = (cnt_r == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
  end

  assign done     = done_r;
  assign quotient = quot_r;

endmodule
`default_nettype wire

### design/etpe_checker.sv
// port-level checks for the eased tween position engine, bound to the top level
`default_nettype none
module etpe_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic [1:0]         in_opcode,
  input wire logic [31:0]        in_now_ms,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [16:0]        out_raw_progress,
  input wire logic signed [17:0] out_eased_progress,
  input wire logic signed [15:0] out_pos_x,
  input wire logic signed [15:0] out_pos_y,
  input wire logic               out_finished,
  input wire logic               cfg_valid,
  input wire logic               cfg_ready,
  input wire logic [2:0]         cfg_index,
  input wire logic [31:0]        cfg_data
);
  import etpe_pkg::*;

  // a finished item always reports full progress
  a_fin_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished |-> out_raw_progress == 17'd65536)
    else $error("finished item without full progress");

  // an unfinished item stays below full progress
  a_run_partial: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_finished |-> out_raw_progress < 17'd65536)
    else $error("unfinished item at full progress");

  // start and stop requests never give a result item
  a_req_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_opcode == OP_START || in_opcode == OP_STOP)
    |=> !$rose(out_valid))
    else $error("result item after a request");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_raw_progress)
      && $stable(out_pos_x) && $stable(out_pos_y))
    else $error("stalled result item changed");

endmodule

bind eased_tween_position_engine etpe_checker u_etpe_checker (.*);
`default_nettype wire
